// File: rtl/npwr_pkg.sv
// ----------------------------------------------------------------------------
// npwr_pkg
// Shared field widths, item kinds and the controller/datapath interface types
// of the nearest-point-within-radius block.
// ----------------------------------------------------------------------------
package npwr_pkg;

  localparam int ID_W    = 32;
  localparam int COORD_W = 26;
  localparam int RAD_W   = 25;
  localparam int DIST_W  = 54;
  // Exact sum of two 26-bit squares.
  localparam int SUM_W   = 2 * COORD_W + 1;
  localparam int LIMIT_W = 2 * RAD_W;
  localparam int WORD_W  = ID_W + 2 * COORD_W;

  localparam logic KIND_INSERT = 1'b0;
  localparam logic KIND_QUERY  = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic insert;
    logic query;
    logic scan_issue;
    logic out_load;
  } npwr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic store_empty;
    logic scan_last;
    logic pipe_busy;
  } npwr_status_t;

endpackage

// File: rtl/nearest_point_within_radius.sv
// ----------------------------------------------------------------------------
// nearest_point_within_radius
// Point store with a nearest-neighbor query by linear scan.
// ----------------------------------------------------------------------------
// An insert item (tuser = 0) appends a point to a store of STORE_DEPTH entries
// and widens the bounding box; it gives no result, and an insert into a full
// store is dropped. A query item (tuser = 1) reads every stored point from the
// store, one per cycle, through a four-stage distance pipeline (the memory
// read and three arithmetic stages). With N stored points the controller
// issues N reads, waits for the pipeline to empty and then loads the result
// into the output register; on an empty store the scan is skipped. The next
// item is taken in the cycle after that load. The block takes no new item
// while a query runs. The result waits in an output register, so inserts are
// taken while it is still pending; a following query finishes its scan and
// then waits for that register to empty.
// ----------------------------------------------------------------------------
module nearest_point_within_radius #(
  parameter int STORE_DEPTH = 1024,
  localparam int CountW     = $clog2(STORE_DEPTH + 1),
  localparam int InDataW    = 112,
  localparam int OutDataW   = ((190 + CountW + 7) / 8) * 8
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid_i,
  output logic                s_axis_tready_o,
  // point_id[31:0], coord_x[57:32], coord_y[83:58], search_radius[108:84]
  input  logic [InDataW-1:0]  s_axis_tdata_i,
  // kind[0]
  input  logic [0:0]          s_axis_tuser_i,
  output logic                m_axis_tvalid_o,
  input  logic                m_axis_tready_i,
  // nearest_id[31:0], nearest_dist_sq[85:32], box_min_x[111:86],
  // box_max_x[137:112], box_min_y[163:138], box_max_y[189:164],
  // point_count[189+CountW:190], zero fill above
  output logic [OutDataW-1:0] m_axis_tdata_o,
  // found[0]
  output logic [0:0]          m_axis_tuser_o
);
  import npwr_pkg::*;

  npwr_cmd_t                 cmd;
  npwr_status_t              status;
  logic                      found;
  logic [ID_W-1:0]           nearest_id;
  logic [DIST_W-1:0]         nearest_dist_sq;
  logic signed [COORD_W-1:0] box_min_x, box_max_x, box_min_y, box_max_y;
  logic [CountW-1:0]         point_count;

  npwr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_kind_i  (s_axis_tuser_i[0]),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .cmd_o      (cmd),
    .status_i   (status)
  );

  npwr_dpath #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_dpath (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .cmd_i            (cmd),
    .status_o         (status),
    .point_id_i       (s_axis_tdata_i[31:0]),
    .coord_x_i        (s_axis_tdata_i[57:32]),
    .coord_y_i        (s_axis_tdata_i[83:58]),
    .search_radius_i  (s_axis_tdata_i[108:84]),
    .found_o          (found),
    .nearest_id_o     (nearest_id),
    .nearest_dist_sq_o(nearest_dist_sq),
    .box_min_x_o      (box_min_x),
    .box_max_x_o      (box_max_x),
    .box_min_y_o      (box_min_y),
    .box_max_y_o      (box_max_y),
    .point_count_o    (point_count)
  );

  assign m_axis_tuser_o = found;
  assign m_axis_tdata_o = OutDataW'({point_count, box_max_y, box_min_y, box_max_x,
                                     box_min_x, nearest_dist_sq, nearest_id});

endmodule

// File: rtl/npwr_ram.sv
// ----------------------------------------------------------------------------
// npwr_ram
// Generic single-clock RAM with one write port and one registered read port.
// ----------------------------------------------------------------------------
module npwr_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: rtl/npwr_ctrl.sv
// ----------------------------------------------------------------------------
// npwr_ctrl
// Controller: accepts items, sequences the store scan for a query and hands
// the finished result to the output register.
// ----------------------------------------------------------------------------
module npwr_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  logic                  in_kind_i,
  output logic                  in_ready_o,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output npwr_pkg::npwr_cmd_t    cmd_o,
  input  npwr_pkg::npwr_status_t status_i
);
  import npwr_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH,
    ST_DONE
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    cmd_o            = '0;
    cmd_o.insert     = accept && (in_kind_i == KIND_INSERT);
    cmd_o.query      = accept && (in_kind_i == KIND_QUERY);
    cmd_o.scan_issue = (state_q == ST_SCAN);
    cmd_o.out_load   = (state_q == ST_DONE) && out_free;
  end

  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      ST_IDLE: begin
        if (cmd_o.query) begin
          // An empty store has nothing to read; go straight to the wrap-up.
          state_d = status_i.store_empty ? ST_FLUSH : ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (status_i.scan_last) begin
          state_d = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        if (!status_i.pipe_busy) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          state_d     = ST_IDLE;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

// File: rtl/npwr_dpath.sv
// ----------------------------------------------------------------------------
// npwr_dpath
// Datapath: point store, bounding box, scan address counter, the distance
// pipeline with the running best match, and the result register.
// ----------------------------------------------------------------------------
module npwr_dpath #(
  parameter int STORE_DEPTH = 1024,
  localparam int CountW     = $clog2(STORE_DEPTH + 1),
  localparam int IdxW       = $clog2(STORE_DEPTH)
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  npwr_pkg::npwr_cmd_t                   cmd_i,
  output npwr_pkg::npwr_status_t                status_o,
  input  logic [npwr_pkg::ID_W-1:0]            point_id_i,
  input  logic signed [npwr_pkg::COORD_W-1:0]  coord_x_i,
  input  logic signed [npwr_pkg::COORD_W-1:0]  coord_y_i,
  input  logic [npwr_pkg::RAD_W-1:0]           search_radius_i,
  output logic                                 found_o,
  output logic [npwr_pkg::ID_W-1:0]            nearest_id_o,
  output logic [npwr_pkg::DIST_W-1:0]          nearest_dist_sq_o,
  output logic signed [npwr_pkg::COORD_W-1:0]  box_min_x_o,
  output logic signed [npwr_pkg::COORD_W-1:0]  box_max_x_o,
  output logic signed [npwr_pkg::COORD_W-1:0]  box_min_y_o,
  output logic signed [npwr_pkg::COORD_W-1:0]  box_max_y_o,
  output logic [CountW-1:0]                    point_count_o
);
  import npwr_pkg::*;

  // Store, count and box.
  logic [CountW-1:0]         count_q;
  logic                      store_full;
  logic                      do_write;
  logic                      box_valid_q;
  logic signed [COORD_W-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q;
  logic [WORD_W-1:0]         rd_word;

  // Query and scan.
  logic signed [COORD_W-1:0] qx_q, qy_q;
  logic [RAD_W-1:0]          rad_q;
  logic [LIMIT_W-1:0]        limit_q;
  logic [IdxW-1:0]           idx_q;
  logic [CountW-1:0]         idx_plus1;

  // Distance pipeline.
  logic                      v1_q, v2_q, v3_q, v4_q;
  logic [ID_W-1:0]           rd_id;
  logic signed [COORD_W-1:0] rd_x, rd_y;
  logic signed [COORD_W:0]   dx, dy;
  logic [COORD_W:0]          adx, ady;
  logic [COORD_W-1:0]        ax_q, ay_q;
  logic [ID_W-1:0]           id2_q, id3_q, id4_q;
  logic [2*COORD_W-1:0]      sqx_q, sqy_q;
  logic [SUM_W-1:0]          d4_q;
  logic                      in_range, better;

  // Best match.
  logic                      hit_q;
  logic [ID_W-1:0]           best_id_q;
  logic [SUM_W-1:0]          best_d_q;

  // Result register.
  logic                      out_found_q;
  logic [ID_W-1:0]           out_id_q;
  logic [SUM_W-1:0]          out_d_q;
  logic signed [COORD_W-1:0] out_lo_x_q, out_hi_x_q, out_lo_y_q, out_hi_y_q;
  logic [CountW-1:0]         out_count_q;

  assign store_full = (count_q == CountW'(STORE_DEPTH));
  assign do_write   = cmd_i.insert && !store_full;
  assign idx_plus1  = CountW'(idx_q) + CountW'(1);

  npwr_ram #(
    .Width(WORD_W),
    .Depth(STORE_DEPTH)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (do_write),
    .waddr_i(count_q[IdxW-1:0]),
    .wdata_i({point_id_i, coord_x_i, coord_y_i}),
    .re_i   (cmd_i.scan_issue),
    .raddr_i(idx_q),
    .rdata_o(rd_word)
  );

  assign rd_id = rd_word[WORD_W-1 -: ID_W];
  assign rd_x  = rd_word[2*COORD_W-1 -: COORD_W];
  assign rd_y  = rd_word[COORD_W-1:0];

  assign dx  = {rd_x[COORD_W-1], rd_x} - {qx_q[COORD_W-1], qx_q};
  assign dy  = {rd_y[COORD_W-1], rd_y} - {qy_q[COORD_W-1], qy_q};
  // The magnitude of a difference of two coordinates stays below 2**26.
  assign adx = dx[COORD_W] ? -dx : dx;
  assign ady = dy[COORD_W] ? -dy : dy;

  assign in_range = (d4_q < SUM_W'(limit_q));
  assign better   = !hit_q || (d4_q < best_d_q) || ((d4_q == best_d_q) && (id4_q < best_id_q));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      box_valid_q <= 1'b0;
      lo_x_q      <= '0;
      hi_x_q      <= '0;
      lo_y_q      <= '0;
      hi_y_q      <= '0;
      idx_q       <= '0;
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      hit_q       <= 1'b0;
    end else begin
      if (do_write) begin
        count_q     <= count_q + CountW'(1);
        box_valid_q <= 1'b1;
        if (!box_valid_q) begin
          lo_x_q <= coord_x_i;
          hi_x_q <= coord_x_i;
          lo_y_q <= coord_y_i;
          hi_y_q <= coord_y_i;
        end else begin
          if (coord_x_i < lo_x_q) lo_x_q <= coord_x_i;
          if (coord_x_i > hi_x_q) hi_x_q <= coord_x_i;
          if (coord_y_i < lo_y_q) lo_y_q <= coord_y_i;
          if (coord_y_i > hi_y_q) hi_y_q <= coord_y_i;
        end
      end
      if (cmd_i.query) begin
        idx_q <= '0;
      end else if (cmd_i.scan_issue) begin
        idx_q <= idx_q + IdxW'(1);
      end
      v1_q <= cmd_i.scan_issue;
      v2_q <= v1_q;
      v3_q <= v2_q;
      v4_q <= v3_q;
      if (cmd_i.query) begin
        hit_q <= 1'b0;
      end else if (v4_q && in_range && better) begin
        hit_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.query) begin
      qx_q      <= coord_x_i;
      qy_q      <= coord_y_i;
      rad_q     <= search_radius_i;
      best_id_q <= '0;
      best_d_q  <= '0;
    end else if (v4_q && in_range && better) begin
      best_id_q <= id4_q;
      best_d_q  <= d4_q;
    end
    // The limit is settled long before the first distance reaches the compare.
    limit_q <= {{RAD_W{1'b0}}, rad_q} * {{RAD_W{1'b0}}, rad_q};
    ax_q    <= adx[COORD_W-1:0];
    ay_q    <= ady[COORD_W-1:0];
    id2_q   <= rd_id;
    sqx_q   <= {{COORD_W{1'b0}}, ax_q} * {{COORD_W{1'b0}}, ax_q};
    sqy_q   <= {{COORD_W{1'b0}}, ay_q} * {{COORD_W{1'b0}}, ay_q};
    id3_q   <= id2_q;
    d4_q    <= {1'b0, sqx_q} + {1'b0, sqy_q};
    id4_q   <= id3_q;
    if (cmd_i.out_load) begin
      out_found_q <= hit_q;
      out_id_q    <= best_id_q;
      out_d_q     <= best_d_q;
      out_lo_x_q  <= lo_x_q;
      out_hi_x_q  <= hi_x_q;
      out_lo_y_q  <= lo_y_q;
      out_hi_y_q  <= hi_y_q;
      out_count_q <= count_q;
    end
  end

  always_comb begin
    status_o             = '0;
    status_o.store_empty = (count_q == '0);
    status_o.scan_last   = (idx_plus1 == count_q);
    status_o.pipe_busy   = v1_q || v2_q || v3_q || v4_q;
  end

  assign found_o           = out_found_q;
  assign nearest_id_o      = out_id_q;
  assign nearest_dist_sq_o = DIST_W'(out_d_q);
  assign box_min_x_o       = out_lo_x_q;
  assign box_max_x_o       = out_hi_x_q;
  assign box_min_y_o       = out_lo_y_q;
  assign box_max_y_o       = out_hi_y_q;
  assign point_count_o     = out_count_q;

endmodule
